FILE: rtl/core/c5vwf_pkg.sv
// ----------------------------------------------------------------------------
// c5vwf_pkg: shared types and constants
// Widths, register indexes and the request record passed from front to back.
// ----------------------------------------------------------------------------
package c5vwf_pkg;

    localparam int MAX_SIDE_DEF    = 1024;
    localparam int KERNEL_SIZE_DEF = 5;
    localparam int PIXEL_BITS_DEF  = 16;
    localparam int KSZ             = 5;
    localparam int COEF_BITS       = 12;
    localparam int ROW_BITS        = 60;
    localparam int SIDE_BITS       = 11;
    localparam int POS_BITS        = 10;
    localparam int SUM_BITS        = 34;
    localparam int CFG_IDX_BITS    = 3;
    localparam int PIX_IN_BITS     = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_SIDE  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF0 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF4 = 3'd5;

    // One 5x5 window with its position, handed from the front to the back end.
    typedef struct packed {
        logic [KSZ*KSZ*PIX_IN_BITS-1:0] win;
        logic [POS_BITS-1:0]            row;
        logic [POS_BITS-1:0]            col;
        logic                           last;
    } t_win_req;

    typedef struct packed {
        logic [POS_BITS-1:0] out_row;
        logic [POS_BITS-1:0] out_col;
        logic [SUM_BITS-1:0] window_sum;
        logic                frame_last;
    } t_result;

endpackage

FILE: rtl/core/c5vwf_if.sv
// ----------------------------------------------------------------------------
// c5vwf_if: valid/ready channel
// Carries one request payload between a source and a sink.
// ----------------------------------------------------------------------------
interface c5vwf_if #(
    parameter int WIDTH = 16
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/conv5x5_valid_window_filter_core.sv
// ----------------------------------------------------------------------------
// conv5x5_valid_window_filter_core: 5x5 valid-window convolution
// Streams a square image and emits one weighted window sum per valid window.
// ----------------------------------------------------------------------------
// The block accepts one pixel per clock in raster order and sustains one pixel
// per cycle while the result output is not held; each valid window (row and
// column at most side-5) yields a result once it has passed the line-buffer
// read stage, the request register, the queue and the four-stage multiply and
// adder pipeline. Four line RAMs of MAX_SIDE entries, each with one write and
// one read port, hold the previous rows, and a two-entry queue decouples the
// pixel front end from the arithmetic. Configure only while idle.
module conv5x5_valid_window_filter_core
    import c5vwf_pkg::*;
#(
    parameter int MAX_SIDE    = MAX_SIDE_DEF,
    parameter int KERNEL_SIZE = KERNEL_SIZE_DEF,
    parameter int PIXEL_BITS  = PIXEL_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [ROW_BITS-1:0]       i_cfg_data,
    c5vwf_if.sink                     s_pix,
    c5vwf_if.source                   m_res
);
    logic [SIDE_BITS-1:0] r_side;
    logic [ROW_BITS-1:0]  r_coef [KERNEL_SIZE];
    logic                 f_valid, f_ready, q_valid, q_ready;
    t_win_req             f_req, q_req;
    t_result              res;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_BITS'(512);
            for (int k = 0; k < KERNEL_SIZE; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_SIDE) begin
                r_side <= i_cfg_data[SIDE_BITS-1:0];
            end else if (i_cfg_idx >= REG_COEF0 && i_cfg_idx <= REG_COEF4) begin
                r_coef[i_cfg_idx - REG_COEF0] <= i_cfg_data;
            end
        end
    end

    c5vwf_front #(.MAX_SIDE(MAX_SIDE), .PIXEL_BITS(PIXEL_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_side_raw (r_side),
        .i_pix_valid(s_pix.valid),
        .o_pix_ready(s_pix.ready),
        .i_pix      (s_pix.data),
        .o_req_valid(f_valid),
        .i_req_ready(f_ready),
        .o_req      (f_req)
    );

    c5vwf_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(f_valid),
        .o_ready(f_ready),
        .i_data (f_req),
        .o_valid(q_valid),
        .i_ready(q_ready),
        .o_data (q_req)
    );

    c5vwf_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_coef (r_coef),
        .i_valid(q_valid),
        .o_ready(q_ready),
        .i_req  (q_req),
        .o_valid(m_res.valid),
        .i_ready(m_res.ready),
        .o_res  (res)
    );

    assign m_res.data = res;

`ifndef SYNTHESIS
    a_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && i_cfg_idx == REG_SIDE |=> r_side == $past(i_cfg_data[SIDE_BITS-1:0]))
        else $error("side register not written");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_res.valid && res.frame_last |-> res.out_row == res.out_col)
        else $error("frame end off the diagonal");
    a_qflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid && !f_ready |=> f_valid)
        else $error("front request dropped");
`endif
endmodule

FILE: rtl/core/c5vwf_ram.sv
// ----------------------------------------------------------------------------
// c5vwf_ram: generic simple dual-port RAM
// One write and one registered read per cycle at independent addresses.
// ----------------------------------------------------------------------------
module c5vwf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read data is held while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end
endmodule

FILE: rtl/core/c5vwf_front.sv
// ----------------------------------------------------------------------------
// c5vwf_front: pixel front end
// Tracks position, reads and updates the line buffers, shifts the window and
// emits a window request for each valid position.
// ----------------------------------------------------------------------------
module c5vwf_front
    import c5vwf_pkg::*;
#(
    parameter int MAX_SIDE   = MAX_SIDE_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [SIDE_BITS-1:0] i_side_raw,
    input  logic                 i_pix_valid,
    output logic                 o_pix_ready,
    input  logic [PIX_IN_BITS-1:0] i_pix,
    output logic                 o_req_valid,
    input  logic                 i_req_ready,
    output t_win_req             o_req
);
    localparam int AW = $clog2(MAX_SIDE);
    localparam int CW = AW + 1;

    logic [CW-1:0] r_col, r_row;
    logic [CW-1:0] side;
    logic [CW-1:0] col_a, row_a, col_n, row_n;
    logic          acc, s1_adv, s1_go;
    logic          r_s1_v;
    logic [PIX_IN_BITS-1:0] r_s1_pix;
    logic [CW-1:0] r_s1_row, r_s1_col, r_s1_side;
    logic [PIX_IN_BITS-1:0] rd [KSZ-1];
    logic [PIX_IN_BITS-1:0] col_v [KSZ];
    logic [PIX_IN_BITS-1:0] r_win [KSZ][KSZ];
    logic          r_ov;
    t_win_req      r_req;
    logic          emit;

    // Clamp the configured side to the supported range.
    always_comb begin
        if (i_side_raw < SIDE_BITS'(KSZ)) begin
            side = CW'(KSZ);
        end else if ({{(CW > SIDE_BITS ? CW - SIDE_BITS : 0){1'b0}}, i_side_raw}
                     > (CW > SIDE_BITS ? CW : SIDE_BITS)'(MAX_SIDE)) begin
            side = CW'(MAX_SIDE);
        end else begin
            side = CW'(i_side_raw);
        end
    end

    // Wrap the counters if the side shrank, then compute the next position.
    always_comb begin
        col_a = r_col;
        row_a = r_row;
        if (col_a >= side) begin
            col_a = '0;
            row_a = row_a + 1'b1;
        end
        if (row_a >= side) begin
            row_a = '0;
        end
        col_n = col_a + 1'b1;
        row_n = row_a;
        if (col_n >= side) begin
            col_n = '0;
            row_n = row_a + 1'b1;
            if (row_n >= side) begin
                row_n = '0;
            end
        end
    end

    // Stage 1 holds its pixel while the request register is held and not taken;
    // a new pixel is taken whenever stage 1 is empty or moving on.
    assign s1_adv      = !r_ov || i_req_ready;
    assign s1_go       = r_s1_v && s1_adv;
    assign o_pix_ready = !r_s1_v || s1_adv;
    assign acc         = i_pix_valid && o_pix_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
        end else begin
            if (acc) begin
                r_col <= col_n;
                r_row <= row_n;
            end
            r_s1_v <= acc || (r_s1_v && !s1_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pix  <= PIX_IN_BITS'(i_pix[PIXEL_BITS-1:0]);
            r_s1_row  <= row_a;
            r_s1_col  <= col_a;
            r_s1_side <= side;
        end
    end

    // Line buffers: lane r is read at the column and refilled with lane r+1.
    for (genvar g = 0; g < KSZ - 1; g++) begin : g_line
        logic [PIX_IN_BITS-1:0] wd;
        if (g == KSZ - 2) begin : g_top
            assign wd = r_s1_pix;
        end else begin : g_mid
            assign wd = rd[g+1];
        end
        c5vwf_ram #(.WIDTH(PIX_IN_BITS), .DEPTH(MAX_SIDE)) u_line (
            .i_clk  (i_clk),
            .i_we   (s1_go),
            .i_waddr(r_s1_col[AW-1:0]),
            .i_wdata(wd),
            .i_re   (acc),
            .i_raddr(col_a[AW-1:0]),
            .o_rdata(rd[g])
        );
    end

    always_comb begin
        for (int r = 0; r < KSZ - 1; r++) begin
            col_v[r] = rd[r];
        end
        col_v[KSZ-1] = r_s1_pix;
    end

    assign emit = r_s1_v && r_s1_row >= CW'(KSZ - 1) && r_s1_col >= CW'(KSZ - 1);

    // Window shift and output request register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < KSZ; r++) begin
                for (int c = 0; c < KSZ; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (s1_go) begin
            for (int r = 0; r < KSZ; r++) begin
                for (int c = 0; c < KSZ - 1; c++) begin
                    r_win[r][c] <= r_win[r][c+1];
                end
                r_win[r][KSZ-1] <= col_v[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (s1_adv) begin
            r_ov <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && emit) begin
            for (int r = 0; r < KSZ; r++) begin
                for (int c = 0; c < KSZ - 1; c++) begin
                    r_req.win[(r*KSZ+c)*PIX_IN_BITS +: PIX_IN_BITS] <= r_win[r][c+1];
                end
                r_req.win[(r*KSZ+KSZ-1)*PIX_IN_BITS +: PIX_IN_BITS] <= col_v[r];
            end
            r_req.row  <= POS_BITS'(r_s1_row - CW'(KSZ - 1));
            r_req.col  <= POS_BITS'(r_s1_col - CW'(KSZ - 1));
            r_req.last <= (r_s1_row == r_s1_side - 1'b1) && (r_s1_col == r_s1_side - 1'b1);
        end
    end

    assign o_req_valid = r_ov;
    assign o_req       = r_req;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_req_ready |=> r_ov && $stable(r_req))
        else $error("front request changed while stalled");
    a_emit_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && s1_adv |=> r_ov)
        else $error("valid window lost");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_col < CW'(MAX_SIDE))
        else $error("column counter out of range");
`endif
endmodule

FILE: rtl/core/c5vwf_fifo.sv
// ----------------------------------------------------------------------------
// c5vwf_fifo: request queue
// Two-entry queue between the front and the back end.
// ----------------------------------------------------------------------------
module c5vwf_fifo
    import c5vwf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_win_req i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_win_req o_data
);
    t_win_req   r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    // Pointer and count update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue overflow");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 && !rd |=> r_cnt == 2'd2)
        else $error("full queue lost an entry");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 && !wr |=> !o_valid)
        else $error("empty queue produced data");
`endif
endmodule

FILE: rtl/core/c5vwf_back.sv
// ----------------------------------------------------------------------------
// c5vwf_back: multiply-accumulate back end
// Registered products, registered row sums and final sum, and an output register.
// ----------------------------------------------------------------------------
module c5vwf_back
    import c5vwf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [ROW_BITS-1:0] i_coef [KSZ],
    input  logic                i_valid,
    output logic                o_ready,
    input  t_win_req            i_req,
    output logic                o_valid,
    input  logic                i_ready,
    output t_result             o_res
);
    localparam int NP = KSZ * KSZ;
    localparam int PW = PIX_IN_BITS + COEF_BITS + 1;

    // Stage valids: 0 products, 1 row sums, 2 final sum, 3 output.
    logic [3:0] r_v;
    logic       adv;
    logic signed [PW-1:0]       r_prod [NP];
    logic signed [SUM_BITS-1:0] r_rsum [KSZ];
    logic signed [SUM_BITS-1:0] rs_c [KSZ];
    logic signed [SUM_BITS-1:0] r_sum;
    logic [POS_BITS-1:0] r_row [3];
    logic [POS_BITS-1:0] r_col [3];
    logic [2:0]          r_last;
    t_result             r_out;

    // Whole pipeline moves unless the output is held.
    assign adv     = !r_v[3] || i_ready;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // One product per tap: unsigned pixel times signed coefficient.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < KSZ; r++) begin
                for (int c = 0; c < KSZ; c++) begin
                    r_prod[r*KSZ+c] <= $signed({1'b0,
                        i_req.win[(r*KSZ+c)*PIX_IN_BITS +: PIX_IN_BITS]})
                        * $signed(i_coef[r][c*COEF_BITS +: COEF_BITS]);
                end
            end
            r_row[0]  <= i_req.row;
            r_col[0]  <= i_req.col;
            r_last[0] <= i_req.last;
        end
    end

    always_comb begin
        for (int r = 0; r < KSZ; r++) begin
            rs_c[r] = '0;
            for (int c = 0; c < KSZ; c++) begin
                rs_c[r] = rs_c[r] + SUM_BITS'(r_prod[r*KSZ+c]);
            end
        end
    end

    // Row sums, then the final sum, then the output register.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rsum    <= rs_c;
            r_sum     <= r_rsum[0] + r_rsum[1] + r_rsum[2] + r_rsum[3] + r_rsum[4];
            r_row[1]  <= r_row[0];
            r_col[1]  <= r_col[0];
            r_last[1] <= r_last[0];
            r_row[2]  <= r_row[1];
            r_col[2]  <= r_col[1];
            r_last[2] <= r_last[1];
            r_out.out_row    <= r_row[2];
            r_out.out_col    <= r_col[2];
            r_out.window_sum <= r_sum;
            r_out.frame_last <= r_last[2];
        end
    end

    assign o_valid = r_v[3];
    assign o_res   = r_out;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(r_out))
        else $error("result changed while stalled");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && adv |=> r_v[0])
        else $error("request lost at pipeline entry");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_v))
        else $error("pipeline moved during stall");
`endif
endmodule

FILE: sim/conv5x5_valid_window_filter_core_tb.sv
// ----------------------------------------------------------------------------
// conv5x5_valid_window_filter_core_tb: self-checking bench for the 5x5 filter
// Streams small square images through the block with random gaps on both
// sides and compares every window result with an in-bench predictor.
// ----------------------------------------------------------------------------
module conv5x5_valid_window_filter_core_tb;
    import c5vwf_pkg::*;

    localparam int LIM_SIDE    = 1024;
    localparam int SETTLE      = 40;
    localparam int HOLD_CYCLES = 150;

    // One row of the directed stimulus: a pixel and, optionally, a known sum.
    typedef struct {
        logic [PIX_IN_BITS-1:0] pix;
        logic                   has_sum;
        logic [SUM_BITS-1:0]    sum;
    } t_pix_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [ROW_BITS-1:0] i_cfg_data;

    c5vwf_if #(.WIDTH(PIX_IN_BITS)) pix_ch ();
    c5vwf_if #(.WIDTH($bits(t_result))) res_ch ();

    conv5x5_valid_window_filter_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_pix      (pix_ch.sink),
        .m_res      (res_ch.source)
    );

    // Predictor state.
    logic [SIDE_BITS-1:0] pm_side;
    logic [ROW_BITS-1:0] pm_coef [KSZ];
    logic [PIX_IN_BITS-1:0] pm_lines [KSZ-1][LIM_SIDE];
    logic [PIX_IN_BITS-1:0] pm_win [KSZ][KSZ];
    int unsigned pm_col;
    int unsigned pm_row;

    t_result expected_results [$];
    int errors;
    bit hold_off;

    always #6 i_clk = ~i_clk;

    // Clamp the programmed side to the supported range.
    function automatic int unsigned active_side();
        int unsigned s;
        s = pm_side;
        if (s < KSZ) s = KSZ;
        if (s > LIM_SIDE) s = LIM_SIDE;
        return s;
    endfunction

    function automatic logic signed [SUM_BITS-1:0] window_dot();
        logic signed [SUM_BITS-1:0] acc;
        logic signed [COEF_BITS-1:0] k;
        acc = '0;
        for (int r = 0; r < KSZ; r++)
            for (int c = 0; c < KSZ; c++) begin
                k = pm_coef[r][COEF_BITS*c +: COEF_BITS];
                acc += $signed({1'b0, pm_win[r][c]}) * k;
            end
        return acc;
    endfunction

    // Advance the predictor by one pixel; queue the window result if any.
    task automatic filter_pixel(input logic [PIX_IN_BITS-1:0] pix);
        int unsigned side;
        logic [PIX_IN_BITS-1:0] column [KSZ];
        t_result res;
        side = active_side();
        if (pm_col >= side) begin
            pm_col = 0;
            pm_row++;
        end
        if (pm_row >= side) pm_row = 0;
        for (int r = 0; r < KSZ - 1; r++) column[r] = pm_lines[r][pm_col];
        column[KSZ-1] = pix;
        for (int r = 0; r < KSZ - 1; r++) pm_lines[r][pm_col] = column[r+1];
        for (int r = 0; r < KSZ; r++) begin
            for (int c = 0; c < KSZ - 1; c++) pm_win[r][c] = pm_win[r][c+1];
            pm_win[r][KSZ-1] = column[r];
        end
        if (pm_row >= KSZ - 1 && pm_col >= KSZ - 1) begin
            res.out_row    = POS_BITS'(pm_row - (KSZ - 1));
            res.out_col    = POS_BITS'(pm_col - (KSZ - 1));
            res.window_sum = window_dot();
            res.frame_last = (pm_row == side - 1) && (pm_col == side - 1);
            expected_results.push_back(res);
        end
        pm_col++;
        if (pm_col >= side) begin
            pm_col = 0;
            pm_row++;
            if (pm_row >= side) pm_row = 0;
        end
    endtask

    // Write one register at an idle point, mirroring it in the predictor.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [ROW_BITS-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        if (idx == REG_SIDE) pm_side = value[SIDE_BITS-1:0];
        else if (idx >= REG_COEF0 && idx <= REG_COEF4) pm_coef[idx - REG_COEF0] = value;
    endtask

    // Close a run of register writes.
    task automatic end_writes();
        i_cfg_we <= 1'b0;
    endtask

    // Offer one pixel and wait until the block takes the request.
    task automatic send_pixel(input logic [PIX_IN_BITS-1:0] pix, input bit gaps);
        int unsigned gap;
        gap = gaps ? $urandom_range(15, 0) : 0;
        if (gap != 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.data  <= pix;
        do @(posedge i_clk); while (!pix_ch.ready);
        filter_pixel(pix);
    endtask

    task automatic wait_drained();
        pix_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [ROW_BITS-1:0] rand_coef_row();
        return ROW_BITS'({$urandom(), $urandom()});
    endfunction

    // Random pixel: mostly uniform, sometimes pinned to an extreme.
    function automatic logic [PIX_IN_BITS-1:0] rand_pixel();
        case ($urandom_range(7, 0))
            0: return '0;
            1: return '1;
            default: return PIX_IN_BITS'($urandom());
        endcase
    endfunction

    // Result checker with random stalls and one long hold-off.
    initial begin
        t_result got;
        t_result want;
        int unsigned stall;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(15, 0);
            if (hold_off) begin
                // Long hold-off: the sender keeps going and the block fills up.
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            got = res_ch.data;
            if (expected_results.size() == 0) begin
                $error("result with no request pending: row %0d col %0d",
                       got.out_row, got.out_col);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.out_row !== want.out_row) begin
                    $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
                    errors++;
                end
                if (got.out_col !== want.out_col) begin
                    $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
                    errors++;
                end
                if (got.window_sum !== want.window_sum) begin
                    $error("window_sum: expected %h, got %h", want.window_sum,
                           got.window_sum);
                    errors++;
                end
                if (got.frame_last !== want.frame_last) begin
                    $error("frame_last: expected %0d, got %0d", want.frame_last,
                           got.frame_last);
                    errors++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random frames.
    initial begin
        t_pix_row dir_rows [$];
        t_pix_row row;
        int unsigned sent;
        int unsigned side;
        int unsigned n;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        pix_ch.valid = 1'b0;
        pix_ch.data = '0;
        hold_off = 1'b0;
        errors = 0;
        pm_side = SIDE_BITS'(512);
        pm_col = 0;
        pm_row = 0;
        for (int r = 0; r < KSZ; r++) begin
            pm_coef[r] = '0;
            for (int c = 0; c < KSZ; c++) pm_win[r][c] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Side below the minimum clamps to five; coefficient at the most negative
        // value in the bottom right corner only, so the sum reads off one pixel.
        write_reg(REG_SIDE, ROW_BITS'(0));
        for (int r = 0; r < KSZ; r++)
            write_reg(REG_COEF0 + CFG_IDX_BITS'(r),
                      (r == KSZ - 1) ? {12'h800, 48'h0} : '0);
        write_reg(3'd6, '1);
        write_reg(3'd7, '1);
        end_writes();
        // A 5x5 frame: first window appears on the last pixel.
        for (int i = 0; i < 25; i++) begin
            row.pix = (i == 24) ? 16'hFFFF : PIX_IN_BITS'(i * 2731);
            row.has_sum = (i == 24);
            row.sum = SUM_BITS'(-(64'sd65535 * 64'sd2048));
            dir_rows.push_back(row);
        end
        foreach (dir_rows[i]) begin
            send_pixel(dir_rows[i].pix, 1'b0);
            if (dir_rows[i].has_sum && expected_results.size() != 0 &&
                expected_results[$].window_sum !== dir_rows[i].sum) begin
                $error("window_sum: expected %h, got %h", dir_rows[i].sum,
                       expected_results[$].window_sum);
                errors++;
            end
        end
        wait_drained();

        // Random frames with side and kernel changed between frames. The block's
        // position carries over, so a frame after a partial one starts mid-image.
        sent = 0;
        n = 0;
        while (sent < 700) begin
            case (n % 4)
                0: side = KSZ;
                1: side = $urandom_range(12, 6);
                default: side = $urandom_range(9, 5);
            endcase
            if (n == 3) side = 2047;
            write_reg(REG_SIDE, ROW_BITS'(side));
            for (int r = 0; r < KSZ; r++)
                write_reg(REG_COEF0 + CFG_IDX_BITS'(r),
                          (n == 1) ? '1 : (n == 2) ? {5{12'h7FF}} : rand_coef_row());
            end_writes();
            side = active_side();
            if (side > 12) begin
                // Side above the maximum clamps; a short partial first row only.
                for (int i = 0; i < 40; i++) begin
                    send_pixel(rand_pixel(), $urandom_range(1, 0));
                    sent++;
                end
            end else begin
                if (n == 5) hold_off = 1'b1;
                for (int i = 0; i < side * side; i++) begin
                    send_pixel(rand_pixel(), n != 5 && $urandom_range(1, 0));
                    sent++;
                end
            end
            wait_drained();
            n++;
        end

        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Time limit for a run that stops making progress.
    initial begin
        #60000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
